// File: rtl/core/ordered_bracket_match_checker_defines.svh
// ----------------------------------------------------------------------------
// Ordered bracket match checker - assertion macros
// Concurrent assertion helpers clocked on clk_i, with and without reset guard.
// ----------------------------------------------------------------------------
`ifndef ORDERED_BRACKET_MATCH_CHECKER_DEFINES_SVH
`define ORDERED_BRACKET_MATCH_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define OBMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("obmc assertion failed");
`define OBMC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("obmc assertion failed");
`else
`define OBMC_ASSERT(lbl, prop)
`define OBMC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: rtl/core/obmc_pkg.sv
// ----------------------------------------------------------------------------
// Ordered bracket match checker - package
// Bracket kinds, character codes, stack control struct and the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package obmc_pkg;

  localparam int unsigned StackDepthDef = 64;

  // rank order: brace above square above paren above angle
  typedef enum logic [1:0] {
    KIND_BRACE  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_PAREN  = 2'd2,
    KIND_ANGLE  = 2'd3
  } kind_e;

  localparam logic [7:0] ChrBraceOpen   = 8'h7B;
  localparam logic [7:0] ChrSquareOpen  = 8'h5B;
  localparam logic [7:0] ChrParenOpen   = 8'h28;
  localparam logic [7:0] ChrAngleOpen   = 8'h3C;
  localparam logic [7:0] ChrBraceClose  = 8'h7D;
  localparam logic [7:0] ChrSquareClose = 8'h5D;
  localparam logic [7:0] ChrParenClose  = 8'h29;
  localparam logic [7:0] ChrAngleClose  = 8'h3E;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_e kind;
  } char_class_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    kind_e push_kind;
  } stack_ctl_t;

  function automatic char_class_t classify(logic [7:0] c);
    char_class_t r;
    r.is_open  = 1'b0;
    r.is_close = 1'b0;
    r.kind     = KIND_BRACE;
    unique case (c)
      ChrBraceOpen:   begin r.is_open  = 1'b1; r.kind = KIND_BRACE;  end
      ChrSquareOpen:  begin r.is_open  = 1'b1; r.kind = KIND_SQUARE; end
      ChrParenOpen:   begin r.is_open  = 1'b1; r.kind = KIND_PAREN;  end
      ChrAngleOpen:   begin r.is_open  = 1'b1; r.kind = KIND_ANGLE;  end
      ChrBraceClose:  begin r.is_close = 1'b1; r.kind = KIND_BRACE;  end
      ChrSquareClose: begin r.is_close = 1'b1; r.kind = KIND_SQUARE; end
      ChrParenClose:  begin r.is_close = 1'b1; r.kind = KIND_PAREN;  end
      ChrAngleClose:  begin r.is_close = 1'b1; r.kind = KIND_ANGLE;  end
      default:        r.kind = KIND_BRACE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/obmc_if.sv
// ----------------------------------------------------------------------------
// Ordered bracket match checker - channel interfaces
// Valid/ready channels for characters in and verdicts out.
// ----------------------------------------------------------------------------
`default_nettype none

interface obmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source (output valid, char_code, end_of_string, input ready);
  modport sink   (input valid, char_code, end_of_string, output ready);
endinterface

interface obmc_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflowed;

  modport source (output valid, matched, overflowed, input ready);
  modport sink   (input valid, matched, overflowed, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ordered_bracket_match_checker.sv
// ----------------------------------------------------------------------------
// Ordered bracket match checker - top level
// Checks nesting and ordering of { [ ( < per string, one verdict per string.
// ----------------------------------------------------------------------------
// One character is accepted every cycle while the verdict register is free or
// being drained. The bracket stack is a row of shift cells with the top kind
// always in cell 0, so push, pop or skip completes in the accept cycle. The
// verdict for a string comes in the cycle after its last character is taken.
// After the first error in a string the rest of it is ignored; overflowed is
// set only when a push on a full stack was that first error.
`default_nettype none
`include "ordered_bracket_match_checker_defines.svh"

module ordered_bracket_match_checker #(
  parameter int unsigned StackDepth = obmc_pkg::StackDepthDef
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  obmc_in_if.sink  in_i,
  obmc_out_if.source out_o
);
  import obmc_pkg::*;

  localparam int unsigned CntW = $clog2(StackDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(StackDepth);

  logic [CntW-1:0] count_d, count_q;
  logic            fail_d, fail_q;
  logic            ovf_d, ovf_q;
  logic            out_valid_d, out_valid_q;
  logic            matched_d, matched_q;
  logic            overflowed_d, overflowed_q;

  logic            in_acc;
  logic            empty, full;
  char_class_t     cls;
  kind_e           top_kind;
  stack_ctl_t      ctl;
  logic [CntW-1:0] count_nx;
  logic            fail_nx, ovf_nx;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_acc     = in_i.valid & in_i.ready;
  assign cls        = classify(in_i.char_code);
  assign empty      = (count_q == '0);
  assign full       = (count_q == CntFull);

  obmc_stack #(
    .StackDepth (StackDepth)
  ) u_stack (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .top_kind_o (top_kind)
  );

  always_comb begin
    ctl.push      = 1'b0;
    ctl.pop       = 1'b0;
    ctl.push_kind = cls.kind;
    count_nx      = count_q;
    fail_nx       = fail_q;
    ovf_nx        = ovf_q;
    if (in_acc && !fail_q) begin
      if (cls.is_open) begin
        if (!empty && (top_kind > cls.kind)) begin
          fail_nx = 1'b1;
        end else if (full) begin
          fail_nx = 1'b1;
          ovf_nx  = 1'b1;
        end else begin
          ctl.push = 1'b1;
          count_nx = count_q + 1'b1;
        end
      end else if (cls.is_close) begin
        if (empty || (top_kind != cls.kind)) begin
          fail_nx = 1'b1;
        end else begin
          ctl.pop  = 1'b1;
          count_nx = count_q - 1'b1;
        end
      end
    end
  end

  always_comb begin
    count_d      = count_nx;
    fail_d       = fail_nx;
    ovf_d        = ovf_nx;
    matched_d    = matched_q;
    overflowed_d = overflowed_q;
    out_valid_d  = out_valid_q & ~out_o.ready;
    if (in_acc && in_i.end_of_string) begin
      matched_d    = ~fail_nx & (count_nx == '0);
      overflowed_d = ovf_nx;
      out_valid_d  = 1'b1;
      count_d      = '0;
      fail_d       = 1'b0;
      ovf_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      fail_q      <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      fail_q      <= fail_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q    <= matched_d;
    overflowed_q <= overflowed_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.matched    = matched_q;
  assign out_o.overflowed = overflowed_q;

  `OBMC_ASSERT(a_count_bound, count_q <= CntFull)
  `OBMC_ASSERT(a_ovf_implies_fail, ovf_q |-> fail_q)
  `OBMC_ASSERT(a_eos_clears, (in_acc && in_i.end_of_string) |=> (count_q == '0 && !fail_q))
  `OBMC_ASSERT(a_verdict_source, $rose(out_valid_q) |-> $past(in_acc && in_i.end_of_string))

endmodule

`default_nettype wire

// File: rtl/core/obmc_cell.sv
// ----------------------------------------------------------------------------
// Ordered bracket match checker - stack cell
// Holds one bracket kind; takes the upper neighbor on push, the lower on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module obmc_cell (
  input  wire                  clk_i,
  input  obmc_pkg::stack_ctl_t ctl_i,
  input  obmc_pkg::kind_e      up_kind_i,
  input  obmc_pkg::kind_e      down_kind_i,
  output obmc_pkg::kind_e      kind_o
);
  import obmc_pkg::*;

  kind_e kind_d, kind_q;

  always_comb begin
    priority if (ctl_i.push) begin
      kind_d = up_kind_i;
    end else if (ctl_i.pop) begin
      kind_d = down_kind_i;
    end else begin
      kind_d = kind_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;

endmodule

`default_nettype wire

// File: rtl/core/obmc_stack.sv
// ----------------------------------------------------------------------------
// Ordered bracket match checker - shift stack
// Row of cells; cell 0 is top of stack, push shifts down, pop shifts up.
// ----------------------------------------------------------------------------
`default_nettype none

module obmc_stack #(
  parameter int unsigned StackDepth = obmc_pkg::StackDepthDef
) (
  input  wire                  clk_i,
  input  obmc_pkg::stack_ctl_t ctl_i,
  output obmc_pkg::kind_e      top_kind_o
);
  import obmc_pkg::*;

  kind_e kinds [StackDepth];

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    kind_e up_kind, down_kind;

    if (i == 0) begin : g_top
      assign up_kind = ctl_i.push_kind;
    end else begin : g_mid
      assign up_kind = kinds[i-1];
    end

    if (i == StackDepth - 1) begin : g_bottom
      assign down_kind = kinds[i];
    end else begin : g_inner
      assign down_kind = kinds[i+1];
    end

    obmc_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl_i),
      .up_kind_i   (up_kind),
      .down_kind_i (down_kind),
      .kind_o      (kinds[i])
    );
  end

  assign top_kind_o = kinds[0];

endmodule

`default_nettype wire

// File: dv/ordered_bracket_match_checker_tb.sv
// ----------------------------------------------------------------------------
// Ordered bracket match checker - testbench
// Drives strings of bytes through the character channel and checks each
// verdict against a bracket stack kept alongside the block. Directed strings
// first, then random nested strings with noise, corruption and deep stacks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_bracket_match_checker_tb;
  import obmc_pkg::*;

  localparam int unsigned StackDepth = StackDepthDef;
  localparam int unsigned RandomChars = 1800;

  typedef struct packed {
    logic [7:0] code;
    logic       eos;
  } char_item_t;

  typedef struct packed {
    logic matched;
    logic overflowed;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  obmc_in_if  in_ch ();
  obmc_out_if out_ch ();

  ordered_bracket_match_checker i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  char_item_t  pending_chars[$];
  verdict_t    expected_verdicts[$];
  char_item_t  cur_char;

  kind_e       open_stack[StackDepth];
  int unsigned open_depth;
  bit          string_failed;
  bit          string_overflowed;

  int unsigned chars_queued;
  int unsigned chars_taken;
  int unsigned verdicts_seen;
  int unsigned verdicts_balanced;
  int unsigned verdicts_overflowed;
  int unsigned err_count;

  logic        in_taken;
  logic        out_taken;
  int unsigned send_gap;
  int unsigned recv_wait;
  int unsigned deep_strings;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned draw_wait();
    if (((chars_taken >> 7) & 3) == 3) return 0;
    return $urandom_range(0, 7);
  endfunction

  function automatic void decode_char(input logic [7:0] c, output bit is_open,
                                      output bit is_close, output kind_e k);
    is_open  = 1'b0;
    is_close = 1'b0;
    k        = KIND_BRACE;
    case (c)
      ChrBraceOpen:   begin is_open  = 1'b1; k = KIND_BRACE;  end
      ChrSquareOpen:  begin is_open  = 1'b1; k = KIND_SQUARE; end
      ChrParenOpen:   begin is_open  = 1'b1; k = KIND_PAREN;  end
      ChrAngleOpen:   begin is_open  = 1'b1; k = KIND_ANGLE;  end
      ChrBraceClose:  begin is_close = 1'b1; k = KIND_BRACE;  end
      ChrSquareClose: begin is_close = 1'b1; k = KIND_SQUARE; end
      ChrParenClose:  begin is_close = 1'b1; k = KIND_PAREN;  end
      ChrAngleClose:  begin is_close = 1'b1; k = KIND_ANGLE;  end
      default:        k = KIND_BRACE;
    endcase
  endfunction

  function automatic void predict_char(logic [7:0] c, logic eos);
    bit       is_open;
    bit       is_close;
    kind_e    k;
    verdict_t v;
    decode_char(c, is_open, is_close, k);
    if (!string_failed) begin
      if (is_open) begin
        if (open_depth != 0 && open_stack[open_depth - 1] > k) begin
          string_failed = 1'b1;
        end else if (open_depth >= StackDepth) begin
          string_failed     = 1'b1;
          string_overflowed = 1'b1;
        end else begin
          open_stack[open_depth] = k;
          open_depth++;
        end
      end else if (is_close) begin
        if (open_depth == 0 || open_stack[open_depth - 1] != k) string_failed = 1'b1;
        else open_depth--;
      end
    end
    if (eos) begin
      v.matched    = !string_failed && open_depth == 0;
      v.overflowed = string_overflowed;
      expected_verdicts.push_back(v);
      open_depth        = 0;
      string_failed     = 1'b0;
      string_overflowed = 1'b0;
    end
  endfunction

  function automatic logic [7:0] open_chr(kind_e k);
    case (k)
      KIND_BRACE:  return ChrBraceOpen;
      KIND_SQUARE: return ChrSquareOpen;
      KIND_PAREN:  return ChrParenOpen;
      default:     return ChrAngleOpen;
    endcase
  endfunction

  function automatic logic [7:0] close_chr(kind_e k);
    case (k)
      KIND_BRACE:  return ChrBraceClose;
      KIND_SQUARE: return ChrSquareClose;
      KIND_PAREN:  return ChrParenClose;
      default:     return ChrAngleClose;
    endcase
  endfunction

  function automatic logic [7:0] noise_chr();
    logic [7:0] c;
    bit         o;
    bit         cl;
    kind_e      k;
    do begin
      c = 8'($urandom_range(0, 255));
      decode_char(c, o, cl, k);
    end while (o || cl);
    return c;
  endfunction

  function automatic logic [7:0] any_bracket();
    kind_e k;
    k = kind_e'($urandom_range(0, 3));
    return $urandom_range(0, 1) ? open_chr(k) : close_chr(k);
  endfunction

  function automatic char_item_t mk_item(logic [7:0] c);
    char_item_t it;
    it.code = c;
    it.eos  = 1'b0;
    return it;
  endfunction

  task automatic queue_string(ref char_item_t s[$]);
    s[$].eos = 1'b1;
    foreach (s[i]) pending_chars.push_back(s[i]);
    chars_queued += s.size();
  endtask

  task automatic queue_text(string txt);
    char_item_t s[$];
    for (int i = 0; i < txt.len(); i++) s.push_back(mk_item(txt[i]));
    queue_string(s);
  endtask

  task automatic queue_byte_string(logic [7:0] c);
    char_item_t s[$];
    s.push_back(mk_item(c));
    queue_string(s);
  endtask

  task automatic gen_nested(int unsigned goal, bit corrupt, bit leave_open);
    char_item_t  s[$];
    kind_e       opened[$];
    kind_e       k;
    int unsigned r;
    int unsigned lo;
    for (int i = 0; i < goal; i++) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        lo = (opened.size() != 0) ? int'(opened[$]) : 0;
        k  = kind_e'($urandom_range(lo, 3));
        opened.push_back(k);
        s.push_back(mk_item(open_chr(k)));
      end else if (r < 7 && opened.size() != 0) begin
        s.push_back(mk_item(close_chr(opened.pop_back())));
      end else begin
        s.push_back(mk_item(noise_chr()));
      end
    end
    if (!leave_open) begin
      while (opened.size() != 0) begin
        if ($urandom_range(0, 4) == 0) s.push_back(mk_item(noise_chr()));
        s.push_back(mk_item(close_chr(opened.pop_back())));
      end
    end
    if (corrupt) s[$urandom_range(0, s.size() - 1)].code = any_bracket();
    queue_string(s);
  endtask

  task automatic gen_deep(int unsigned depth, bit corrupt);
    char_item_t s[$];
    kind_e      opened[$];
    kind_e      k;
    k = kind_e'($urandom_range(0, 3));
    for (int i = 0; i < depth; i++) begin
      if ($urandom_range(0, 7) == 0 && k != KIND_ANGLE) k = kind_e'(int'(k) + 1);
      opened.push_back(k);
      s.push_back(mk_item(open_chr(k)));
      if ($urandom_range(0, 5) == 0) s.push_back(mk_item(noise_chr()));
    end
    while (opened.size() != 0) s.push_back(mk_item(close_chr(opened.pop_back())));
    if (corrupt) s[$urandom_range(0, s.size() - 1)].code = any_bracket();
    queue_string(s);
  endtask

  task automatic wait_drained();
    while (chars_taken != chars_queued || expected_verdicts.size() != 0) @(negedge clk_i);
  endtask

  // sender
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_taken)) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (pending_chars.size() != 0) begin
        cur_char = pending_chars.pop_front();
        in_ch.char_code     <= cur_char.code;
        in_ch.end_of_string <= cur_char.eos;
        in_ch.valid         <= 1'b1;
        send_gap = draw_wait();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_taken) recv_wait = draw_wait();
      if (recv_wait > 0) begin
        out_ch.ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on every character transaction, check every verdict
  always @(posedge clk_i) begin
    verdict_t want;
    in_taken  <= rst_ni && in_ch.valid && in_ch.ready;
    out_taken <= rst_ni && out_ch.valid && out_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        chars_taken++;
        predict_char(in_ch.char_code, in_ch.end_of_string);
      end
      if (out_ch.valid && out_ch.ready) begin
        verdicts_seen++;
        if (out_ch.matched === 1'b1) verdicts_balanced++;
        if (out_ch.overflowed === 1'b1) verdicts_overflowed++;
        if (expected_verdicts.size() == 0) begin
          $error("unexpected verdict: matched=%0b overflowed=%0b",
                 out_ch.matched, out_ch.overflowed);
          err_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_ch.matched !== want.matched) begin
            $error("matched: expected %0b, actual %0b", want.matched, out_ch.matched);
            err_count++;
          end
          if (out_ch.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b, actual %0b", want.overflowed,
                   out_ch.overflowed);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned guard;
    int unsigned goal;
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.char_code     = 8'h00;
    in_ch.end_of_string = 1'b0;
    out_ch.ready        = 1'b0;
    in_taken            = 1'b0;
    out_taken           = 1'b0;
    send_gap            = 0;
    recv_wait           = 0;
    open_depth          = 0;
    string_failed       = 1'b0;
    string_overflowed   = 1'b0;
    chars_queued        = 0;
    chars_taken         = 0;
    verdicts_seen       = 0;
    verdicts_balanced   = 0;
    verdicts_overflowed = 0;
    err_count           = 0;
    deep_strings        = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_byte_string(8'h00);
    queue_byte_string(8'hFF);
    queue_text("{[(<>)]}");
    queue_text("{{}}");
    queue_text("([");
    queue_text("]");
    queue_text("{)");
    queue_text("{");
    queue_text("<x>(");
    wait_drained();

    // full stack without overflow, then one push past the limit
    gen_deep(StackDepth, 1'b0);
    gen_deep(StackDepth + 1, 1'b0);
    deep_strings = 2;

    while (chars_queued < RandomChars) begin
      if ($urandom_range(0, 14) == 0) begin
        gen_deep($urandom_range(StackDepth - 6, StackDepth + 6), $urandom_range(0, 2) == 0);
        deep_strings++;
      end else begin
        goal = $urandom_range(1, 24);
        gen_nested(goal, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
      end
      if (chars_queued > RandomChars / 2 && chars_queued < RandomChars / 2 + 30) begin
        wait_drained();
      end
      while (pending_chars.size() > 64) @(negedge clk_i);
    end

    while (chars_taken != chars_queued) @(negedge clk_i);
    guard = 0;
    while (expected_verdicts.size() != 0 && guard < 2000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);
    if (expected_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", expected_verdicts.size());
      err_count++;
    end

    $display("checked %0d characters, %0d verdicts (%0d balanced, %0d overflowed)",
             chars_taken, verdicts_seen, verdicts_balanced, verdicts_overflowed);
    $display("%0d deep strings near the stack limit, %0d errors", deep_strings, err_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
